@@ hdl/cpi_pkg.sv @@
package cpi_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 8;
   localparam int ID_BITS    = 16;

   // root of (dx^2 + dy^2) * 4^FRAC_BITS
   localparam int DIST_W  = COORD_BITS + FRAC_BITS + 1;
   localparam int SQ_W    = 2 * COORD_BITS + 1;
   localparam int OPND_W  = 2 * DIST_W;
   localparam int REM_W   = DIST_W + 1;
   localparam int COST_W  = DIST_W + 4;
   localparam int OUT_COST_W = 28;

   localparam logic signed [COST_W-1:0] COST_HI = COST_W'(2 ** (OUT_COST_W - 1) - 1);
   localparam logic signed [COST_W-1:0] COST_LO = -COST_HI - COST_W'(1);

   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_APPEND = 2'd1;
   localparam logic [1:0] MODE_INSERT = 2'd2;
   localparam logic [1:0] MODE_READ   = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   localparam logic [1:0] PLACE_NONE     = 2'd0;
   localparam logic [1:0] PLACE_PD       = 2'd1;
   localparam logic [1:0] PLACE_DP       = 2'd2;
   localparam logic [1:0] PLACE_SEPARATE = 2'd3;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [ID_BITS-1:0]    id;
   } point_type;

   function automatic logic signed [COST_W-1:0] to_cost(input logic [DIST_W-1:0] d);
      return $signed({{(COST_W - DIST_W){1'b0}}, d});
   endfunction

endpackage

@@ hdl/cheapest_pair_insertion_unit.sv @@
// Clear and append go straight to the result; read first waits for the RAM output.
// An insert into an empty tour writes both points and measures pickup to delivery.
// Otherwise insert measures pickup to delivery and the distances that rate each tour
// edge, then shifts points up; each distance is one pass of the shared root unit.
// One item at a time: req_stall stays high until the result is in the output register.
// Synchronous reset empties the tour; memory contents are not cleared.
module cheapest_pair_insertion_unit #(
   parameter int MAX_POINTS = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_mode,
   input  logic [15:0]                           req_pickup_x,
   input  logic [15:0]                           req_pickup_y,
   input  logic [15:0]                           req_pickup_id,
   input  logic [15:0]                           req_delivery_x,
   input  logic [15:0]                           req_delivery_y,
   input  logic [15:0]                           req_delivery_id,
   input  logic [7:0]                            req_read_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_status,
   output logic [1:0]                            rsp_placement,
   output logic [7:0]                            rsp_pickup_position,
   output logic [7:0]                            rsp_delivery_position,
   output logic signed [27:0]                    rsp_added_cost,
   output logic [15:0]                           rsp_point_x,
   output logic [15:0]                           rsp_point_y,
   output logic [15:0]                           rsp_point_id,
   output logic [8:0]                            rsp_tour_length
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int DW = cpi_pkg::DIST_W;
   localparam int KW = cpi_pkg::COST_W;

   typedef enum logic [4:0] {
      S_IDLE, S_RDA, S_RDD, S_EMP, S_EMPW, S_PQW, S_PAW, S_QAW, S_EDGE, S_RDB1,
      S_RDB2, S_PBW, S_QBW, S_ABW, S_EVAL, S_UPD, S_SUM, S_CHOOSE, S_SHIFT,
      S_SH1, S_SH2, S_FIN
   } state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   cpi_pkg::point_type        p_ff, p_in, q_ff, q_in, a_ff, a_in, b_ff, b_in;
   cpi_pkg::point_type        first_ff, first_in, ins_ff, ins_in, ins2_ff, ins2_in;
   logic [DW-1:0]             dpq_ff, dpq_in, dpa_ff, dpa_in, dqa_ff, dqa_in;
   logic [DW-1:0]             dp0_ff, dp0_in, dq0_ff, dq0_in, dpb_ff, dpb_in;
   logic [DW-1:0]             dqb_ff, dqb_in, dab_ff, dab_in;
   logic [AW-1:0]             i_ff, i_in, ip_ff, ip_in, id_ff, id_in;
   logic [AW-1:0]             ipd_ff, ipd_in, idp_ff, idp_in;
   logic signed [KW-1:0]      cp_ff, cp_in, cd_ff, cd_in, cpd_ff, cpd_in, cdp_ff, cdp_in;
   logic signed [KW-1:0]      bp_ff, bp_in, bd_ff, bd_in, bpd_ff, bpd_in, bdp_ff, bdp_in;
   logic signed [KW-1:0]      sum_ff, sum_in, cost_ff, cost_in;
   logic [CW-1:0]             k_ff, k_in, pos_ff, pos_in, pos2_ff, pos2_in;
   logic                      second_ff, second_in;
   logic [AW-1:0]             rd_addr_ff, rd_addr_in, wr_addr_ff, wr_addr_in;
   logic                      wr_en_ff, wr_en_in;
   cpi_pkg::point_type        wr_data_ff, wr_data_in, rd_data;
   logic                      dist_start_ff, dist_start_in, dist_done;
   cpi_pkg::point_type        dist_a_ff, dist_a_in, dist_b_ff, dist_b_in;
   logic [DW-1:0]             dist_root;
   logic [1:0]                status_ff, status_in, placement_ff, placement_in;
   logic [7:0]                ppos_ff, ppos_in, dpos_ff, dpos_in;
   cpi_pkg::point_type        pt_ff, pt_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;
   logic [1:0]                rsp_placement_ff, rsp_placement_in;
   logic [7:0]                rsp_ppos_ff, rsp_ppos_in, rsp_dpos_ff, rsp_dpos_in;
   logic signed [27:0]        rsp_cost_ff, rsp_cost_in;
   cpi_pkg::point_type        rsp_pt_ff, rsp_pt_in;
   logic [8:0]                rsp_len_ff, rsp_len_in;

   logic                      accept, out_free, last_edge;
   cpi_pkg::point_type        req_p, req_q;
   logic signed [KW-1:0]      sat_cost;

   cpi_ram #(
      .WIDTH ($bits(cpi_pkg::point_type)),
      .DEPTH (MAX_POINTS)
   ) u_tour (
      .clock   (clock),
      .wr_en   (wr_en_ff),
      .wr_addr (wr_addr_ff),
      .wr_data (wr_data_ff),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   cpi_dist u_dist (
      .clock (clock),
      .reset (reset),
      .start (dist_start_ff),
      .a     (dist_a_ff),
      .b     (dist_b_ff),
      .done  (dist_done),
      .root  (dist_root)
   );

   assign req_stall = reset || (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_edge = (i_ff == AW'(count_ff - CW'(1)));
   assign req_p     = '{x: req_pickup_x, y: req_pickup_y, id: req_pickup_id};
   assign req_q     = '{x: req_delivery_x, y: req_delivery_y, id: req_delivery_id};

   always_comb begin
      if (cost_ff > cpi_pkg::COST_HI) begin
         sat_cost = cpi_pkg::COST_HI;
      end else if (cost_ff < cpi_pkg::COST_LO) begin
         sat_cost = cpi_pkg::COST_LO;
      end else begin
         sat_cost = cost_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      p_in          = p_ff;
      q_in          = q_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      first_in      = first_ff;
      ins_in        = ins_ff;
      ins2_in       = ins2_ff;
      dpq_in        = dpq_ff;
      dpa_in        = dpa_ff;
      dqa_in        = dqa_ff;
      dp0_in        = dp0_ff;
      dq0_in        = dq0_ff;
      dpb_in        = dpb_ff;
      dqb_in        = dqb_ff;
      dab_in        = dab_ff;
      i_in          = i_ff;
      ip_in         = ip_ff;
      id_in         = id_ff;
      ipd_in        = ipd_ff;
      idp_in        = idp_ff;
      cp_in         = cp_ff;
      cd_in         = cd_ff;
      cpd_in        = cpd_ff;
      cdp_in        = cdp_ff;
      bp_in         = bp_ff;
      bd_in         = bd_ff;
      bpd_in        = bpd_ff;
      bdp_in        = bdp_ff;
      sum_in        = sum_ff;
      cost_in       = cost_ff;
      k_in          = k_ff;
      pos_in        = pos_ff;
      pos2_in       = pos2_ff;
      second_in     = second_ff;
      rd_addr_in    = rd_addr_ff;
      wr_addr_in    = wr_addr_ff;
      wr_en_in      = 1'b0;
      wr_data_in    = wr_data_ff;
      dist_start_in = 1'b0;
      dist_a_in     = dist_a_ff;
      dist_b_in     = dist_b_ff;
      status_in     = status_ff;
      placement_in  = placement_ff;
      ppos_in       = ppos_ff;
      dpos_in       = dpos_ff;
      pt_in         = pt_ff;

      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_status_in    = rsp_status_ff;
      rsp_placement_in = rsp_placement_ff;
      rsp_ppos_in      = rsp_ppos_ff;
      rsp_dpos_in      = rsp_dpos_ff;
      rsp_cost_in      = rsp_cost_ff;
      rsp_pt_in        = rsp_pt_ff;
      rsp_len_in       = rsp_len_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               p_in         = req_p;
               q_in         = req_q;
               status_in    = cpi_pkg::STATUS_OK;
               placement_in = cpi_pkg::PLACE_NONE;
               ppos_in      = '0;
               dpos_in      = '0;
               cost_in      = '0;
               pt_in        = '0;
               state_in     = S_FIN;
               case (req_mode)
                  cpi_pkg::MODE_CLEAR: begin
                     count_in = '0;
                  end
                  cpi_pkg::MODE_APPEND: begin
                     if (count_ff >= CW'(MAX_POINTS)) begin
                        status_in = cpi_pkg::STATUS_FULL;
                     end else begin
                        wr_en_in   = 1'b1;
                        wr_addr_in = AW'(count_ff);
                        wr_data_in = req_p;
                        count_in   = count_ff + CW'(1);
                     end
                  end
                  cpi_pkg::MODE_READ: begin
                     if (32'(req_read_index) >= 32'(count_ff)) begin
                        status_in = cpi_pkg::STATUS_RANGE;
                     end else begin
                        rd_addr_in = AW'(req_read_index);
                        state_in   = S_RDA;
                     end
                  end
                  default: begin
                     if (32'(count_ff) + 32'd2 > 32'(MAX_POINTS)) begin
                        status_in = cpi_pkg::STATUS_FULL;
                     end else if (count_ff == '0) begin
                        wr_en_in   = 1'b1;
                        wr_addr_in = '0;
                        wr_data_in = req_p;
                        state_in   = S_EMP;
                     end else begin
                        dist_start_in = 1'b1;
                        dist_a_in     = req_p;
                        dist_b_in     = req_q;
                        rd_addr_in    = '0;
                        state_in      = S_PQW;
                     end
                  end
               endcase
            end
         end
         S_RDA: state_in = S_RDD;
         S_RDD: begin
            pt_in    = rd_data;
            state_in = S_FIN;
         end
         S_EMP: begin
            wr_en_in      = 1'b1;
            wr_addr_in    = AW'(1);
            wr_data_in    = q_ff;
            count_in      = CW'(2);
            dist_start_in = 1'b1;
            dist_a_in     = p_ff;
            dist_b_in     = q_ff;
            state_in      = S_EMPW;
         end
         S_EMPW: begin
            if (dist_done) begin
               cost_in      = cpi_pkg::to_cost(dist_root) <<< 1;
               placement_in = cpi_pkg::PLACE_PD;
               ppos_in      = 8'd0;
               dpos_in      = 8'd1;
               state_in     = S_FIN;
            end
         end
         S_PQW: begin
            if (dist_done) begin
               dpq_in        = dist_root;
               a_in          = rd_data;
               first_in      = rd_data;
               dist_start_in = 1'b1;
               dist_a_in     = p_ff;
               dist_b_in     = rd_data;
               state_in      = S_PAW;
            end
         end
         S_PAW: begin
            if (dist_done) begin
               dpa_in        = dist_root;
               dp0_in        = dist_root;
               dist_start_in = 1'b1;
               dist_a_in     = q_ff;
               dist_b_in     = a_ff;
               state_in      = S_QAW;
            end
         end
         S_QAW: begin
            if (dist_done) begin
               dqa_in   = dist_root;
               dq0_in   = dist_root;
               i_in     = '0;
               state_in = S_EDGE;
            end
         end
         S_EDGE: begin
            if (last_edge) begin
               // closing edge wraps to the first point
               b_in          = first_ff;
               dpb_in        = dp0_ff;
               dqb_in        = dq0_ff;
               dist_start_in = 1'b1;
               dist_a_in     = a_ff;
               dist_b_in     = first_ff;
               state_in      = S_ABW;
            end else begin
               rd_addr_in = i_ff + AW'(1);
               state_in   = S_RDB1;
            end
         end
         S_RDB1: state_in = S_RDB2;
         S_RDB2: begin
            b_in          = rd_data;
            dist_start_in = 1'b1;
            dist_a_in     = p_ff;
            dist_b_in     = rd_data;
            state_in      = S_PBW;
         end
         S_PBW: begin
            if (dist_done) begin
               dpb_in        = dist_root;
               dist_start_in = 1'b1;
               dist_a_in     = q_ff;
               dist_b_in     = b_ff;
               state_in      = S_QBW;
            end
         end
         S_QBW: begin
            if (dist_done) begin
               dqb_in        = dist_root;
               dist_start_in = 1'b1;
               dist_a_in     = a_ff;
               dist_b_in     = b_ff;
               state_in      = S_ABW;
            end
         end
         S_ABW: begin
            if (dist_done) begin
               dab_in   = dist_root;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cp_in  = cpi_pkg::to_cost(dpa_ff) + cpi_pkg::to_cost(dpb_ff)
                     - cpi_pkg::to_cost(dab_ff);
            cd_in  = cpi_pkg::to_cost(dqa_ff) + cpi_pkg::to_cost(dqb_ff)
                     - cpi_pkg::to_cost(dab_ff);
            cpd_in = cpi_pkg::to_cost(dpa_ff) + cpi_pkg::to_cost(dqb_ff)
                     + cpi_pkg::to_cost(dpq_ff) - cpi_pkg::to_cost(dab_ff);
            cdp_in = cpi_pkg::to_cost(dpb_ff) + cpi_pkg::to_cost(dqa_ff)
                     + cpi_pkg::to_cost(dpq_ff) - cpi_pkg::to_cost(dab_ff);
            state_in = S_UPD;
         end
         S_UPD: begin
            // strict less: the earliest edge keeps a tie
            if (i_ff == '0 || cp_ff < bp_ff) begin
               bp_in = cp_ff;
               ip_in = i_ff;
            end
            if (i_ff == '0 || cd_ff < bd_ff) begin
               bd_in = cd_ff;
               id_in = i_ff;
            end
            if (i_ff == '0 || cpd_ff < bpd_ff) begin
               bpd_in = cpd_ff;
               ipd_in = i_ff;
            end
            if (i_ff == '0 || cdp_ff < bdp_ff) begin
               bdp_in = cdp_ff;
               idp_in = i_ff;
            end
            a_in   = b_ff;
            dpa_in = dpb_ff;
            dqa_in = dqb_ff;
            if (last_edge) begin
               state_in = S_SUM;
            end else begin
               i_in     = i_ff + AW'(1);
               state_in = S_EDGE;
            end
         end
         S_SUM: begin
            sum_in   = bp_ff + bd_ff;
            state_in = S_CHOOSE;
         end
         S_CHOOSE: begin
            if (bpd_ff < sum_ff || ip_ff == id_ff) begin
               pos_in       = CW'(ipd_ff) + CW'(1);
               pos2_in      = CW'(ipd_ff) + CW'(2);
               ins_in       = p_ff;
               ins2_in      = q_ff;
               ppos_in      = 8'(CW'(ipd_ff) + CW'(1));
               dpos_in      = 8'(CW'(ipd_ff) + CW'(2));
               placement_in = cpi_pkg::PLACE_PD;
               cost_in      = bpd_ff;
            end else if (bdp_ff < sum_ff) begin
               pos_in       = CW'(idp_ff) + CW'(1);
               pos2_in      = CW'(idp_ff) + CW'(2);
               ins_in       = q_ff;
               ins2_in      = p_ff;
               dpos_in      = 8'(CW'(idp_ff) + CW'(1));
               ppos_in      = 8'(CW'(idp_ff) + CW'(2));
               placement_in = cpi_pkg::PLACE_DP;
               cost_in      = bdp_ff;
            end else begin
               if (ip_ff < id_ff) begin
                  pos_in  = CW'(ip_ff) + CW'(1);
                  pos2_in = CW'(id_ff) + CW'(2);
                  ins_in  = p_ff;
                  ins2_in = q_ff;
                  ppos_in = 8'(CW'(ip_ff) + CW'(1));
                  dpos_in = 8'(CW'(id_ff) + CW'(2));
               end else begin
                  pos_in  = CW'(id_ff) + CW'(1);
                  pos2_in = CW'(ip_ff) + CW'(2);
                  ins_in  = q_ff;
                  ins2_in = p_ff;
                  dpos_in = 8'(CW'(id_ff) + CW'(1));
                  ppos_in = 8'(CW'(ip_ff) + CW'(2));
               end
               placement_in = cpi_pkg::PLACE_SEPARATE;
               cost_in      = sum_ff;
            end
            k_in      = count_ff;
            second_in = 1'b1;
            state_in  = S_SHIFT;
         end
         S_SHIFT: begin
            if (k_ff > pos_ff) begin
               rd_addr_in = AW'(k_ff - CW'(1));
               state_in   = S_SH1;
            end else begin
               wr_en_in   = 1'b1;
               wr_addr_in = AW'(pos_ff);
               wr_data_in = ins_ff;
               count_in   = count_ff + CW'(1);
               if (second_ff) begin
                  second_in = 1'b0;
                  pos_in    = pos2_ff;
                  ins_in    = ins2_ff;
                  k_in      = count_ff + CW'(1);
                  state_in  = S_SHIFT;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_SH1: state_in = S_SH2;
         S_SH2: begin
            // move one entry up by one place
            wr_en_in   = 1'b1;
            wr_addr_in = AW'(k_ff);
            wr_data_in = rd_data;
            k_in       = k_ff - CW'(1);
            state_in   = S_SHIFT;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = status_ff;
               rsp_placement_in = placement_ff;
               rsp_ppos_in      = ppos_ff;
               rsp_dpos_in      = dpos_ff;
               rsp_cost_in      = 28'(sat_cost);
               rsp_pt_in        = pt_ff;
               rsp_len_in       = 9'(count_ff);
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         wr_en_ff      <= 1'b0;
         dist_start_ff <= 1'b0;
         second_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         wr_en_ff      <= wr_en_in;
         dist_start_ff <= dist_start_in;
         second_ff     <= second_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      p_ff             <= p_in;
      q_ff             <= q_in;
      a_ff             <= a_in;
      b_ff             <= b_in;
      first_ff         <= first_in;
      ins_ff           <= ins_in;
      ins2_ff          <= ins2_in;
      dpq_ff           <= dpq_in;
      dpa_ff           <= dpa_in;
      dqa_ff           <= dqa_in;
      dp0_ff           <= dp0_in;
      dq0_ff           <= dq0_in;
      dpb_ff           <= dpb_in;
      dqb_ff           <= dqb_in;
      dab_ff           <= dab_in;
      i_ff             <= i_in;
      ip_ff            <= ip_in;
      id_ff            <= id_in;
      ipd_ff           <= ipd_in;
      idp_ff           <= idp_in;
      cp_ff            <= cp_in;
      cd_ff            <= cd_in;
      cpd_ff           <= cpd_in;
      cdp_ff           <= cdp_in;
      bp_ff            <= bp_in;
      bd_ff            <= bd_in;
      bpd_ff           <= bpd_in;
      bdp_ff           <= bdp_in;
      sum_ff           <= sum_in;
      cost_ff          <= cost_in;
      k_ff             <= k_in;
      pos_ff           <= pos_in;
      pos2_ff          <= pos2_in;
      rd_addr_ff       <= rd_addr_in;
      wr_addr_ff       <= wr_addr_in;
      wr_data_ff       <= wr_data_in;
      dist_a_ff        <= dist_a_in;
      dist_b_ff        <= dist_b_in;
      status_ff        <= status_in;
      placement_ff     <= placement_in;
      ppos_ff          <= ppos_in;
      dpos_ff          <= dpos_in;
      pt_ff            <= pt_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_placement_ff <= rsp_placement_in;
      rsp_ppos_ff      <= rsp_ppos_in;
      rsp_dpos_ff      <= rsp_dpos_in;
      rsp_cost_ff      <= rsp_cost_in;
      rsp_pt_ff        <= rsp_pt_in;
      rsp_len_ff       <= rsp_len_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_placement         = rsp_placement_ff;
   assign rsp_pickup_position   = rsp_ppos_ff;
   assign rsp_delivery_position = rsp_dpos_ff;
   assign rsp_added_cost        = rsp_cost_ff;
   assign rsp_point_x           = rsp_pt_ff.x;
   assign rsp_point_y           = rsp_pt_ff.y;
   assign rsp_point_id          = rsp_pt_ff.id;
   assign rsp_tour_length       = rsp_len_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(MAX_POINTS))
      else $error("tour count beyond capacity");

   a_dist_done_waited: assert property (@(posedge clock) disable iff (reset)
      dist_done |-> (state_ff == S_EMPW || state_ff == S_PQW || state_ff == S_PAW ||
                     state_ff == S_QAW || state_ff == S_PBW || state_ff == S_QBW ||
                     state_ff == S_ABW))
      else $error("distance finished outside a wait state");

   a_place_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_placement_ff != cpi_pkg::PLACE_NONE
         |-> rsp_status_ff == cpi_pkg::STATUS_OK)
      else $error("placement reported with error status");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN))
      else $error("result beat raised outside finish");
`endif

endmodule

@@ hdl/cpi_ram.sv @@
module cpi_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/cpi_dist.sv @@
module cpi_dist (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  cpi_pkg::point_type         a,
   input  cpi_pkg::point_type         b,
   output logic                       done,
   output logic [cpi_pkg::DIST_W-1:0] root
);

   localparam int CNT_W = $clog2(cpi_pkg::DIST_W);

   typedef enum logic [1:0] {D_IDLE, D_SQX, D_SQY, D_ROOT} state_type;

   state_type                        state_ff, state_in;
   logic [cpi_pkg::COORD_BITS-1:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic [cpi_pkg::OPND_W-1:0]       opnd_ff, opnd_in;
   logic [cpi_pkg::DIST_W-1:0]       root_ff, root_in;
   logic [cpi_pkg::REM_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic                             done_ff, done_in;

   logic [cpi_pkg::COORD_BITS-1:0]   sq_opnd;
   logic [2*cpi_pkg::COORD_BITS-1:0] sq;
   logic [cpi_pkg::SQ_W-1:0]         sum;
   logic [cpi_pkg::REM_W+1:0]        rem_n, trial;

   always_comb begin
      state_in = state_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      opnd_in  = opnd_ff;
      root_in  = root_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      sq_opnd  = (state_ff == D_SQX) ? dx_ff : dy_ff;
      sq       = sq_opnd * sq_opnd;
      sum      = opnd_ff[cpi_pkg::SQ_W-1:0] + cpi_pkg::SQ_W'(sq);
      rem_n    = {rem_ff, opnd_ff[cpi_pkg::OPND_W-1 -: 2]};
      trial    = (cpi_pkg::REM_W+2)'({root_ff, 2'b01});
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               dx_in    = (a.x > b.x) ? a.x - b.x : b.x - a.x;
               dy_in    = (a.y > b.y) ? a.y - b.y : b.y - a.y;
               root_in  = '0;
               rem_in   = '0;
               cnt_in   = CNT_W'(cpi_pkg::DIST_W - 1);
               state_in = D_SQX;
            end
         end
         D_SQX: begin
            opnd_in  = cpi_pkg::OPND_W'(sq);
            state_in = D_SQY;
         end
         D_SQY: begin
            opnd_in  = cpi_pkg::OPND_W'(sum) << (2 * cpi_pkg::FRAC_BITS);
            state_in = D_ROOT;
         end
         D_ROOT: begin
            // one result bit per step: bring down two operand bits, try 4r+1
            if (rem_n >= trial) begin
               rem_in  = cpi_pkg::REM_W'(rem_n - trial);
               root_in = {root_ff[cpi_pkg::DIST_W-2:0], 1'b1};
            end else begin
               rem_in  = cpi_pkg::REM_W'(rem_n);
               root_in = {root_ff[cpi_pkg::DIST_W-2:0], 1'b0};
            end
            opnd_in = opnd_ff << 2;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      opnd_ff <= opnd_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
